[rtl/bjd_pkg.sv]
// shared types and codes for the bounded job deque
package bjd_pkg;

  localparam int CAP_W = 5;

  typedef logic [1:0] action_t;
  localparam action_t ACT_PUSH_BACK  = 2'd0;
  localparam action_t ACT_PUSH_FRONT = 2'd1;
  localparam action_t ACT_POP_FRONT  = 2'd2;
  localparam action_t ACT_PEEK_FRONT = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  kind;
    logic [31:0] request_time;
    logic [31:0] end_time;
    logic [31:0] turnaround;
    logic [15:0] length;
  } job_t;

  // per-cell move select, one per cell per cycle
  typedef struct packed {
    logic load;
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

endpackage

[rtl/bjd_in_if.sv]
// request channel: action plus the job to add
interface bjd_in_if;
  logic                  valid;
  logic                  ready;
  bjd_pkg::action_t      action;
  logic [15:0]           job_id;
  logic [7:0]            job_kind;
  logic [31:0]           request_time;
  logic [31:0]           end_time;
  logic [31:0]           turnaround_time;
  logic [15:0]           job_length;

  modport source (
    output valid, action, job_id, job_kind, request_time, end_time,
           turnaround_time, job_length,
    input  ready
  );
  modport sink (
    input  valid, action, job_id, job_kind, request_time, end_time,
           turnaround_time, job_length,
    output ready
  );
endinterface

[rtl/bjd_out_if.sv]
// response channel: status, returned job and occupancy
interface bjd_out_if #(
  parameter int COUNT_W = 5
);
  logic                  valid;
  logic                  ready;
  bjd_pkg::status_t      status;
  logic [15:0]           out_id;
  logic [7:0]            out_kind;
  logic [31:0]           out_request_time;
  logic [31:0]           out_end_time;
  logic [31:0]           out_turnaround;
  logic [15:0]           out_length;
  logic [COUNT_W-1:0]    occupancy;
  logic                  is_empty;

  modport source (
    output valid, status, out_id, out_kind, out_request_time, out_end_time,
           out_turnaround, out_length, occupancy, is_empty,
    input  ready
  );
  modport sink (
    input  valid, status, out_id, out_kind, out_request_time, out_end_time,
           out_turnaround, out_length, occupancy, is_empty,
    output ready
  );
endinterface

[rtl/bjd_cell.sv]
// one deque slot: loads a new job or takes its neighbour's job
module bjd_cell (
  input  logic                 clk,
  input  bjd_pkg::cell_ctrl_t  ctrl,
  input  bjd_pkg::job_t        new_job,
  input  bjd_pkg::job_t        prev_job,
  input  bjd_pkg::job_t        next_job,
  output bjd_pkg::job_t        job
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      job <= new_job;
    end else if (ctrl.take_prev) begin
      job <= prev_job;
    end else if (ctrl.take_next) begin
      job <= next_job;
    end
  end

endmodule

[rtl/bounded_job_deque.sv]
// top level of the bounded job deque built as a row of shifting cells
//
// usage: each transfer on req carries one action (push back, push front,
// pop front, peek front) and, for pushes, a job record. every request gives
// exactly one response on rsp with a status (ok, full, empty), the popped or
// peeked job (zero otherwise), the occupancy after the action and an empty
// flag. cfg_we/cfg_data set the capacity; 0 or anything above DEPTH means
// DEPTH. write it only while no response is outstanding.
// jobs sit in a row of DEPTH cells with the front job always in cell 0: a
// push front or a pop shifts the whole row by one cell, while a push back
// loads the cell at the current occupancy.
// the response is registered and appears the cycle after the request.
// throughput: one request per cycle unless rsp stalls (single output reg).
// a stalled rsp holds its response and req.ready drops until it is taken;
// req.ready comes back in the same cycle as the response transfer.
// reset empties the deque, clears capacity to 0 and drops rsp.valid; cell
// contents are not cleared and never read before being written.
module bounded_job_deque #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bjd_pkg::CAP_W-1:0]   cfg_data,
  bjd_in_if.sink                      req,
  bjd_out_if.source                   rsp
);

  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (COUNT_W > bjd_pkg::CAP_W) ? COUNT_W : bjd_pkg::CAP_W;

  logic [bjd_pkg::CAP_W-1:0] capacity;
  logic [COUNT_W-1:0]        count;
  logic [COUNT_W-1:0]        count_next;
  logic                      out_valid;
  bjd_pkg::status_t          out_status;
  bjd_pkg::job_t             out_job;
  logic [COUNT_W-1:0]        out_count;

  bjd_pkg::job_t             new_job;
  bjd_pkg::job_t             cells [DEPTH];
  bjd_pkg::cell_ctrl_t       ctrl  [DEPTH];

  logic [EXT_W-1:0]          eff_cap;
  logic                      accept;
  logic                      is_push;
  logic                      is_full;
  logic                      is_empty_now;
  logic                      push_back_ok;
  logic                      push_front_ok;
  logic                      pop_ok;
  logic                      read_ok;
  bjd_pkg::status_t          status_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;

  assign new_job = '{id: req.job_id, kind: req.job_kind,
                     request_time: req.request_time, end_time: req.end_time,
                     turnaround: req.turnaround_time, length: req.job_length};

  always_comb begin
    if (capacity == '0 || EXT_W'(capacity) > EXT_W'(DEPTH)) begin
      eff_cap = EXT_W'(DEPTH);
    end else begin
      eff_cap = EXT_W'(capacity);
    end
  end

  assign is_push       = req.action == bjd_pkg::ACT_PUSH_BACK ||
                         req.action == bjd_pkg::ACT_PUSH_FRONT;
  assign is_full       = EXT_W'(count) >= eff_cap;
  assign is_empty_now  = count == '0;
  assign push_back_ok  = accept && req.action == bjd_pkg::ACT_PUSH_BACK && !is_full;
  assign push_front_ok = accept && req.action == bjd_pkg::ACT_PUSH_FRONT && !is_full;
  assign read_ok       = !is_push && !is_empty_now;
  assign pop_ok        = accept && req.action == bjd_pkg::ACT_POP_FRONT && !is_empty_now;

  always_comb begin
    count_next = count;
    if (push_back_ok || push_front_ok) begin
      count_next = count + COUNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - COUNT_W'(1);
    end
  end

  always_comb begin
    if (is_push && is_full) begin
      status_next = bjd_pkg::ST_FULL;
    end else if (!is_push && is_empty_now) begin
      status_next = bjd_pkg::ST_EMPTY;
    end else begin
      status_next = bjd_pkg::ST_OK;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bjd_pkg::job_t prev_job;
    bjd_pkg::job_t next_job;

    if (i == 0) begin : g_first
      assign prev_job = new_job;
    end else begin : g_prev
      assign prev_job = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_job = cells[i];
    end else begin : g_next
      assign next_job = cells[i+1];
    end

    // push back lands in the first free cell, push front enters at cell 0
    assign ctrl[i].load      = (push_back_ok && count == COUNT_W'(i)) ||
                               (push_front_ok && i == 0);
    assign ctrl[i].take_prev = push_front_ok && i != 0;
    assign ctrl[i].take_next = pop_ok && i != DEPTH - 1;

    bjd_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .new_job  (new_job),
      .prev_job (prev_job),
      .next_job (next_job),
      .job      (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_count  <= count_next;
      out_job    <= read_ok ? cells[0] : '0;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.out_id           = out_job.id;
  assign rsp.out_kind         = out_job.kind;
  assign rsp.out_request_time = out_job.request_time;
  assign rsp.out_end_time     = out_job.end_time;
  assign rsp.out_turnaround   = out_job.turnaround;
  assign rsp.out_length       = out_job.length;
  assign rsp.occupancy        = out_count;
  assign rsp.is_empty         = out_count == '0;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    EXT_W'(count) <= EXT_W'(DEPTH))
    else $error("occupancy above depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> count == $past(count) - COUNT_W'(1))
    else $error("pop did not reduce occupancy");

  a_full_no_job: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bjd_pkg::ST_FULL |-> out_job == '0)
    else $error("refused push returned job data");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bjd_pkg::ST_EMPTY |-> rsp.is_empty)
    else $error("empty status with jobs held");

  a_push_respects_cap: assert property (@(posedge clk) disable iff (rst)
    (push_back_ok || push_front_ok) |-> EXT_W'(count) < eff_cap)
    else $error("push accepted at capacity");

endmodule
